### rtl/mandelbrot_escape_time_unit_assert.svh
// Assertion macros shared by the escape-time unit checkers.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/met_pkg.sv
`default_nettype none

package met_pkg;

  // Field widths and fixed-point format
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 28;
  localparam int IDX_W      = 10;
  localparam int ITER_W     = 16;
  localparam int SHIFT_W    = 4;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Full-width products and sums
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = PROD_W + 1;
  // Bit position of 4.0 in the squared format
  localparam int ESC_BIT = 2 * FRAC_W + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SHIFT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [SHIFT_W-1:0] COLOR_SHIFT_RST = SHIFT_W'(5);
  localparam logic [ITER_W-1:0]  ITER_LIMIT_RST  = ITER_W'(32768);

  typedef struct packed {
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          row;
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_step;
  } met_in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iter_count;
    logic               inside_set;
    logic [COLOR_W-1:0] color;
  } met_out_t;

  // Clamp a wide signed sum to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] upper;
    upper = v[SUM_W-1:COORD_W-1];
    if (upper == {(SUM_W-COORD_W+1){1'b0}} || upper == {(SUM_W-COORD_W+1){1'b1}}) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/met_mul.sv
`default_nettype none

module met_mul
  import met_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic signed [COORD_W-1:0] a_i,
  input  wire logic signed [COORD_W-1:0] b_i,
  output logic signed [PROD_W-1:0]       prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Full-width signed product, registered
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/mandelbrot_escape_time_unit.sv
// Escape-time pixel unit: one shared registered multiplier under a small sequencer.
// Steps: after an input transfer, S_CX and S_CY form the point, then each iteration runs
// S_TEST, S_FIXV, S_SQU and S_SQV until S_TEST finishes and registers the result.
// One pixel at a time; the next is taken the cycle after the result is registered.
// Reset: rst_ni clears the sequencer and output valid, color_shift to 5 and
// iteration_limit to 32768.
`default_nettype none

module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int MAX_ITER_LIMIT = 32768
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // pixel input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire met_in_t               in_data_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output met_out_t                   out_data_o,
  // register write
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [ITER_W:0] MAX_LIM = (ITER_W+1)'(MAX_ITER_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX,
    S_CY,
    S_TEST,
    S_FIXV,
    S_SQU,
    S_SQV
  } state_e;

  state_e state_q;

  logic               out_valid_q;
  met_out_t           out_q;
  logic [SHIFT_W-1:0] color_shift_q;
  logic [ITER_W-1:0]  iter_limit_q;

  // Datapath registers
  logic [IDX_W-1:0]          row_q;
  logic signed [COORD_W-1:0] x_min_q, y_min_q, y_step_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, u_q, v_q;
  logic signed [PROD_W-1:0]  u2_q, diff_q;
  logic                      esc_q;
  logic [ITER_W-1:0]         k_q;

  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   cx_sum, cy_sum, nu_sum, nv_sum;
  logic [SUM_W-1:0]          mag;
  logic [ITER_W-1:0]         lim_eff;
  logic                      at_limit, finish;
  logic [COLOR_W-1:0]        color;

  // Shared multiplier
  met_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Select multiplier operands for the next step
  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        mul_a = signed'({{(COORD_W-IDX_W){1'b0}}, in_data_i.col});
        mul_b = in_data_i.x_step;
      end
      S_CX: begin
        mul_a = signed'({{(COORD_W-IDX_W){1'b0}}, row_q});
        mul_b = y_step_q;
      end
      S_TEST: begin
        mul_a = u_q;
        mul_b = v_q;
      end
      S_FIXV: begin
        mul_a = u_q;
        mul_b = u_q;
      end
      S_SQU: begin
        mul_a = v_q;
        mul_b = v_q;
      end
      default: begin
        mul_a = u_q;
        mul_b = v_q;
      end
    endcase
  end

  // Point, next z and escape arithmetic
  assign cx_sum = SUM_W'(x_min_q) + SUM_W'(prod);
  assign cy_sum = SUM_W'(y_min_q) + SUM_W'(prod);
  assign nv_sum = SUM_W'(prod >>> (FRAC_W - 1)) + SUM_W'(cy_q);
  assign nu_sum = SUM_W'(diff_q >>> FRAC_W) + SUM_W'(cx_q);
  assign mag    = {1'b0, u2_q} + {1'b0, prod};

  // Clamp the limit and decide termination
  assign lim_eff  = ((ITER_W+1)'(iter_limit_q) > MAX_LIM) ? MAX_LIM[ITER_W-1:0] : iter_limit_q;
  assign at_limit = (k_q == lim_eff);
  assign finish   = at_limit || esc_q;
  assign color    = at_limit ? '0 : COLOR_W'(k_q >> color_shift_q);

  // Datapath updates, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        row_q    <= in_data_i.row;
        x_min_q  <= in_data_i.x_min;
        y_min_q  <= in_data_i.y_min;
        y_step_q <= in_data_i.y_step;
      end
      S_CX: begin
        cx_q <= sat_coord(cx_sum);
      end
      S_CY: begin
        cy_q   <= sat_coord(cy_sum);
        u_q    <= '0;
        v_q    <= '0;
        diff_q <= '0;
        esc_q  <= 1'b0;
        k_q    <= '0;
      end
      S_TEST: begin
        if (!finish) begin
          u_q <= sat_coord(nu_sum);
          k_q <= k_q + ITER_W'(1);
        end
      end
      S_FIXV: begin
        v_q <= sat_coord(nv_sum);
      end
      S_SQU: begin
        u2_q <= prod;
      end
      S_SQV: begin
        diff_q <= u2_q - prod;
        esc_q  <= |mag[SUM_W-1:ESC_BIT];
      end
      default: begin
      end
    endcase
  end

  // Sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop valid after a result transfer unless a new result lands now
      if (out_valid_q && !out_stall_i && !(state_q == S_TEST && finish)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CX;
          end
        end
        S_CX:   state_q <= S_CY;
        S_CY:   state_q <= S_TEST;
        S_TEST: begin
          if (!finish) begin
            state_q <= S_FIXV;
          end else if (!out_valid_q || !out_stall_i) begin
            // Hold here until the previous result has been taken
            out_q.iter_count <= k_q;
            out_q.inside_set <= at_limit;
            out_q.color      <= color;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        S_FIXV: state_q <= S_SQU;
        S_SQU:  state_q <= S_SQV;
        S_SQV:  state_q <= S_TEST;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_shift_q <= COLOR_SHIFT_RST;
      iter_limit_q  <= ITER_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_COLOR_SHIFT) begin
        color_shift_q <= cfg_data_i[SHIFT_W-1:0];
      end else if (cfg_index_i == REG_ITER_LIMIT) begin
        iter_limit_q <= cfg_data_i[ITER_W-1:0];
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

### rtl/met_checker.sv
`default_nettype none

`include "mandelbrot_escape_time_unit_assert.svh"

module met_checker
  import met_pkg::*;
#(
  parameter int MAX_ITER_LIMIT = 32768
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire met_out_t out_data_o
);

  logic in_xfer;
  logic in_range;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign in_range = ({1'b0, out_data_o.iter_count} <= (ITER_W+1)'(MAX_ITER_LIMIT));

  // A stalled result holds
  `MET_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // Points inside the set carry palette zero
  `MET_ASSERT_NOW(a_inside_black, out_valid_o && out_data_o.inside_set,
    out_data_o.color == '0, "inside point has nonzero color")

  // The count never passes the clamp
  `MET_ASSERT_NOW(a_count_range, out_valid_o, in_range, "iteration count above maximum")

  // Busy right after a pixel transfer
  `MET_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall_o, "input not stalled while busy")

endmodule

bind mandelbrot_escape_time_unit met_checker #(
  .MAX_ITER_LIMIT (MAX_ITER_LIMIT)
) u_met_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
